/* rtl/rational_gain_multiply_defines.svh */
// assertion macros used by the checker file
`ifndef RATIONAL_GAIN_MULTIPLY_DEFINES_SVH
`define RATIONAL_GAIN_MULTIPLY_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define RGM_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("rgm check failed");

// consequent must hold in the cycle after the antecedent
`define RGM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rgm check failed");

`endif

/* rtl/rgm_pkg.sv */
`timescale 1ns / 1ps

package rgm_pkg;

  // operand width of the datapath
  localparam int DW    = 64;
  localparam int CNT_W = $clog2(DW);
  localparam int LEN_W = 8;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_INCOMPAT = 2'd2;
  localparam logic [1:0] ST_CAPACITY = 2'd3;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_GCD_INIT,
    OP_GCD_STEP,
    OP_GCD_END,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_END,
    OP_MUL_INIT,
    OP_MUL_STEP,
    OP_MUL_END,
    OP_LEN_INIT,
    OP_LEN_STEP,
    OP_SAVE_NUM,
    OP_SAVE_DEN
  } op_t;

  // operand register selects
  typedef enum logic [2:0] {
    S_AN,
    S_AD,
    S_BN,
    S_BD,
    S_PN,
    S_PD
  } sel_t;

  // command from controller to datapath
  typedef struct packed {
    op_t  op;
    sel_t sa;
    sel_t sb;
    sel_t sd;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic bad;
    logic mismatch;
    logic gcd_done;
    logic cnt_last;
    logic len_last;
    logic ovf;
    logic ge;
  } stat_t;

endpackage

/* rtl/rgm_dp.sv */
`timescale 1ns / 1ps

module rgm_dp
  import rgm_pkg::*;
#(
  parameter int WORD_BITS = 64
) (
  input  logic             clk,
  input  logic [DW-1:0]    left_num,
  input  logic [DW-1:0]    left_den,
  input  logic [DW-1:0]    right_num,
  input  logic [DW-1:0]    right_den,
  input  logic             typing_complete,
  input  logic             typing_match,
  input  cmd_t             cmd_i,
  output stat_t            stat_o,
  output logic [DW-1:0]    pn_o,
  output logic [DW-1:0]    pd_o,
  output logic [LEN_W-1:0] need_num_o,
  output logic [LEN_W-1:0] need_den_o
);

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DW - 1);

  // operand bank
  logic [DW-1:0] an_r, ad_r, bn_r, bd_r, pn_r, pd_r, g_r;
  // shared work registers
  logic [DW-1:0]      x_r, y_r, rem_r, quo_r, mc_r;
  logic [2*DW-1:0]    p_r;
  logic [CNT_W-1:0]   cnt_r, k_r;
  logic [LEN_W-1:0]   len_r, need_num_r, need_den_r;
  logic               bad_r, mm_r, ovf_r;

  logic [DW-1:0]   rd_a, rd_b, wr_data;
  logic [DW:0]     shifted;
  logic [DW+1:0]   diff;
  logic            div_ge;
  logic [DW:0]     mul_sum;
  logic            bad_nxt;

  // operand read ports
  always_comb begin
    case (cmd_i.sa)
      S_AN:    rd_a = an_r;
      S_AD:    rd_a = ad_r;
      S_BN:    rd_a = bn_r;
      S_BD:    rd_a = bd_r;
      S_PN:    rd_a = pn_r;
      S_PD:    rd_a = pd_r;
      default: rd_a = '0;
    endcase
    case (cmd_i.sb)
      S_AN:    rd_b = an_r;
      S_AD:    rd_b = ad_r;
      S_BN:    rd_b = bn_r;
      S_BD:    rd_b = bd_r;
      S_PN:    rd_b = pn_r;
      S_PD:    rd_b = pd_r;
      default: rd_b = '0;
    endcase
  end

  // restoring divide step, shift-add multiply step
  always_comb begin
    shifted = {rem_r, quo_r[DW-1]};
    diff    = {1'b0, shifted} - {2'b00, g_r};
    div_ge  = ~diff[DW+1];
    mul_sum = {1'b0, p_r[2*DW-1:DW]} + (p_r[0] ? {1'b0, mc_r} : '0);
    wr_data = (cmd_i.op == OP_DIV_END) ? quo_r : p_r[DW-1:0];
  end

  // input checks
  assign bad_nxt = !(left_num != '0 && left_den != '0 && left_num < left_den) ||
                   !(right_num != '0 && right_den != '0 && right_num < right_den) ||
                   !typing_complete;

  always_ff @(posedge clk) begin
    case (cmd_i.op)
      OP_LOAD: begin
        an_r  <= left_num;
        ad_r  <= left_den;
        bn_r  <= right_num;
        bd_r  <= right_den;
        bad_r <= bad_nxt;
        mm_r  <= !typing_match;
        ovf_r <= 1'b0;
        len_r <= '0;
        need_num_r <= '0;
        need_den_r <= '0;
      end
      OP_GCD_INIT: begin
        x_r <= rd_a;
        y_r <= rd_b;
        k_r <= '0;
      end
      OP_GCD_STEP: begin
        if (!x_r[0] && !y_r[0]) begin
          x_r <= x_r >> 1;
          y_r <= y_r >> 1;
          k_r <= k_r + CNT_W'(1);
        end else if (!x_r[0]) begin
          x_r <= x_r >> 1;
        end else if (!y_r[0]) begin
          y_r <= y_r >> 1;
        end else if (x_r >= y_r) begin
          x_r <= x_r - y_r;
        end else begin
          y_r <= y_r - x_r;
        end
      end
      OP_GCD_END: g_r <= y_r << k_r;
      OP_DIV_INIT: begin
        rem_r <= '0;
        quo_r <= rd_a;
        cnt_r <= '0;
      end
      OP_DIV_STEP: begin
        rem_r <= div_ge ? diff[DW-1:0] : shifted[DW-1:0];
        quo_r <= {quo_r[DW-2:0], div_ge};
        cnt_r <= cnt_r + CNT_W'(1);
      end
      OP_MUL_INIT: begin
        mc_r  <= rd_a;
        p_r   <= {{DW{1'b0}}, rd_b};
        cnt_r <= '0;
      end
      OP_MUL_STEP: begin
        p_r   <= {mul_sum, p_r[DW-1:1]};
        cnt_r <= cnt_r + CNT_W'(1);
      end
      OP_MUL_END: ovf_r <= ovf_r | (|p_r[2*DW-1:WORD_BITS]);
      OP_LEN_INIT: x_r <= rd_a;
      OP_LEN_STEP: begin
        x_r   <= x_r >> 1;
        len_r <= len_r + LEN_W'(1);
      end
      OP_SAVE_NUM: begin
        need_num_r <= len_r;
        len_r      <= '0;
      end
      OP_SAVE_DEN: begin
        need_den_r <= len_r;
        len_r      <= '0;
      end
      default: ;
    endcase

    // write back of quotients and products
    if (cmd_i.op == OP_DIV_END || cmd_i.op == OP_MUL_END) begin
      case (cmd_i.sd)
        S_AN:    an_r <= wr_data;
        S_AD:    ad_r <= wr_data;
        S_BN:    bn_r <= wr_data;
        S_BD:    bd_r <= wr_data;
        S_PN:    pn_r <= wr_data;
        S_PD:    pd_r <= wr_data;
        default: ;
      endcase
    end
  end

  // status back to the controller
  always_comb begin
    stat_o.bad      = bad_r;
    stat_o.mismatch = mm_r;
    stat_o.gcd_done = (x_r == '0);
    stat_o.cnt_last = (cnt_r == CNT_LAST);
    stat_o.len_last = (x_r[DW-1:1] == '0);
    stat_o.ovf      = ovf_r;
    stat_o.ge       = (pn_r >= pd_r) || (pn_r == '0);
  end

  assign pn_o       = pn_r;
  assign pd_o       = pd_r;
  assign need_num_o = need_num_r;
  assign need_den_o = need_den_r;

endmodule

/* rtl/rgm_ctrl.sv */
`timescale 1ns / 1ps

module rgm_ctrl
  import rgm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  stat_t      stat_i,
  output cmd_t       cmd_o,
  output logic       busy,
  output logic       done,
  output logic [1:0] status
);

  typedef enum logic [2:0] {IDLE, CHECK, ISSUE, RUN, FINISH, DONE} state_t;

  typedef enum logic [3:0] {
    K_GCD, K_DIV, K_MUL, K_LEN, K_SNUM, K_SDEN, K_CHECK, K_OK, K_CAP
  } kind_t;

  typedef struct packed {
    kind_t kind;
    sel_t  sa;
    sel_t  sb;
    sel_t  sd;
  } row_t;

  localparam logic [4:0] LEN_START = 5'd13;

  // sequence of operations for one item
  function automatic row_t prog(input logic [4:0] ph);
    row_t r;
    r = '{K_OK, S_AN, S_AN, S_AN};
    case (ph)
      5'd0:    r = '{K_GCD,   S_AN, S_BD, S_AN};
      5'd1:    r = '{K_DIV,   S_AN, S_AN, S_AN};
      5'd2:    r = '{K_DIV,   S_BD, S_BD, S_BD};
      5'd3:    r = '{K_GCD,   S_BN, S_AD, S_AN};
      5'd4:    r = '{K_DIV,   S_BN, S_BN, S_BN};
      5'd5:    r = '{K_DIV,   S_AD, S_AD, S_AD};
      5'd6:    r = '{K_MUL,   S_AN, S_BN, S_PN};
      5'd7:    r = '{K_MUL,   S_AD, S_BD, S_PD};
      5'd8:    r = '{K_CHECK, S_AN, S_AN, S_AN};
      5'd9:    r = '{K_GCD,   S_PN, S_PD, S_AN};
      5'd10:   r = '{K_DIV,   S_PN, S_PN, S_PN};
      5'd11:   r = '{K_DIV,   S_PD, S_PD, S_PD};
      5'd12:   r = '{K_OK,    S_AN, S_AN, S_AN};
      5'd13:   r = '{K_LEN,   S_AN, S_AN, S_AN};
      5'd14:   r = '{K_LEN,   S_BN, S_BN, S_BN};
      5'd15:   r = '{K_SNUM,  S_AN, S_AN, S_AN};
      5'd16:   r = '{K_LEN,   S_AD, S_AD, S_AD};
      5'd17:   r = '{K_LEN,   S_BD, S_BD, S_BD};
      5'd18:   r = '{K_SDEN,  S_AN, S_AN, S_AN};
      5'd19:   r = '{K_CAP,   S_AN, S_AN, S_AN};
      default: r = '{K_OK,    S_AN, S_AN, S_AN};
    endcase
    return r;
  endfunction

  state_t     state_r, state_nxt;
  logic [4:0] ph_r, ph_nxt;
  logic [1:0] st_r, st_nxt;
  row_t       row;

  // next state and commands
  always_comb begin
    row       = prog(ph_r);
    cmd_o     = '{OP_NONE, row.sa, row.sb, row.sd};
    state_nxt = state_r;
    ph_nxt    = ph_r;
    st_nxt    = st_r;
    case (state_r)
      IDLE: begin
        if (start) begin
          cmd_o.op  = OP_LOAD;
          state_nxt = CHECK;
        end
      end
      CHECK: begin
        if (stat_i.bad) begin
          st_nxt    = ST_INVALID;
          state_nxt = DONE;
        end else if (stat_i.mismatch) begin
          st_nxt    = ST_INCOMPAT;
          state_nxt = DONE;
        end else begin
          ph_nxt    = '0;
          state_nxt = ISSUE;
        end
      end
      ISSUE: begin
        case (row.kind)
          K_GCD: begin
            cmd_o.op  = OP_GCD_INIT;
            state_nxt = RUN;
          end
          K_DIV: begin
            cmd_o.op  = OP_DIV_INIT;
            state_nxt = RUN;
          end
          K_MUL: begin
            cmd_o.op  = OP_MUL_INIT;
            state_nxt = RUN;
          end
          K_LEN: begin
            cmd_o.op  = OP_LEN_INIT;
            state_nxt = RUN;
          end
          K_SNUM: begin
            cmd_o.op = OP_SAVE_NUM;
            ph_nxt   = ph_r + 5'd1;
          end
          K_SDEN: begin
            cmd_o.op = OP_SAVE_DEN;
            ph_nxt   = ph_r + 5'd1;
          end
          K_CHECK: begin
            if (stat_i.ovf) begin
              ph_nxt = LEN_START;
            end else if (stat_i.ge) begin
              st_nxt    = ST_INVALID;
              state_nxt = DONE;
            end else begin
              ph_nxt = ph_r + 5'd1;
            end
          end
          K_OK: begin
            st_nxt    = ST_OK;
            state_nxt = DONE;
          end
          K_CAP: begin
            st_nxt    = ST_CAPACITY;
            state_nxt = DONE;
          end
          default: state_nxt = DONE;
        endcase
      end
      RUN: begin
        case (row.kind)
          K_GCD: begin
            if (stat_i.gcd_done) state_nxt = FINISH;
            else cmd_o.op = OP_GCD_STEP;
          end
          K_DIV: begin
            cmd_o.op = OP_DIV_STEP;
            if (stat_i.cnt_last) state_nxt = FINISH;
          end
          K_MUL: begin
            cmd_o.op = OP_MUL_STEP;
            if (stat_i.cnt_last) state_nxt = FINISH;
          end
          K_LEN: begin
            cmd_o.op = OP_LEN_STEP;
            if (stat_i.len_last) begin
              ph_nxt    = ph_r + 5'd1;
              state_nxt = ISSUE;
            end
          end
          default: state_nxt = ISSUE;
        endcase
      end
      FINISH: begin
        case (row.kind)
          K_GCD:   cmd_o.op = OP_GCD_END;
          K_DIV:   cmd_o.op = OP_DIV_END;
          K_MUL:   cmd_o.op = OP_MUL_END;
          default: cmd_o.op = OP_NONE;
        endcase
        ph_nxt    = ph_r + 5'd1;
        state_nxt = ISSUE;
      end
      DONE:    state_nxt = IDLE;
      default: state_nxt = IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= IDLE;
      ph_r    <= '0;
      st_r    <= ST_OK;
    end else begin
      state_r <= state_nxt;
      ph_r    <= ph_nxt;
      st_r    <= st_nxt;
    end
  end

  assign busy   = (state_r != IDLE);
  assign done   = (state_r == DONE);
  assign status = st_r;

endmodule

/* rtl/rational_gain_multiply.sv */
`timescale 1ns / 1ps
// Multiplies two proper fractions and reduces the product to lowest terms.
// Input channel: an item is taken when start is high and busy is low; all
// in_ fields are sampled at that edge. busy stays high until the result has
// been shown.
// Result channel: out_valid is high for exactly one cycle with out_status,
// the reduced product and the bit-length fields; the receiver cannot stall,
// so the result must be captured in that cycle.
// Processing: an item that fails the input or typing checks goes from CHECK
// straight to DONE. Otherwise the shared datapath does one step per cycle:
// three binary GCDs, six 64-step restoring divides and two 64-step shift-add
// multiplies. A GCD needs up to about 255 steps, near 130 on full-width
// operands. Capacity items end after the bit-length counts instead of the
// last GCD and divides.
// Throughput: one item at a time; the next start is taken the cycle after
// out_valid.
// Reset: synchronous, active low; returns the controller to idle and drops
// any item in progress.
module rational_gain_multiply
  import rgm_pkg::*;
#(
  parameter int WORD_BITS = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [DW-1:0]    in_left_num,
  input  logic [DW-1:0]    in_left_den,
  input  logic [DW-1:0]    in_right_num,
  input  logic [DW-1:0]    in_right_den,
  input  logic             in_typing_complete,
  input  logic             in_typing_match,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic [DW-1:0]    out_product_num,
  output logic [DW-1:0]    out_product_den,
  output logic [LEN_W-1:0] out_need_num_bits,
  output logic [LEN_W-1:0] out_need_den_bits
);

  cmd_t             cmd;
  stat_t            stat;
  logic [DW-1:0]    pn, pd;
  logic [LEN_W-1:0] need_num, need_den;

  rgm_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy   (busy),
    .done   (out_valid),
    .status (out_status)
  );

  rgm_dp #(.WORD_BITS(WORD_BITS)) u_dp (
    .clk             (clk),
    .left_num        (in_left_num),
    .left_den        (in_left_den),
    .right_num       (in_right_num),
    .right_den       (in_right_den),
    .typing_complete (in_typing_complete),
    .typing_match    (in_typing_match),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .pn_o            (pn),
    .pd_o            (pd),
    .need_num_o      (need_num),
    .need_den_o      (need_den)
  );

  // fields that do not apply to the status read as zero
  assign out_product_num   = (out_status == ST_OK) ? pn : '0;
  assign out_product_den   = (out_status == ST_OK) ? pd : '0;
  assign out_need_num_bits = (out_status == ST_CAPACITY) ? need_num : '0;
  assign out_need_den_bits = (out_status == ST_CAPACITY) ? need_den : '0;

endmodule

/* rtl/rgm_checker.sv */
`timescale 1ns / 1ps
`include "rational_gain_multiply_defines.svh"

module rgm_checker
  import rgm_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input logic [DW-1:0]    in_left_num,
  input logic [DW-1:0]    in_left_den,
  input logic [DW-1:0]    in_right_num,
  input logic [DW-1:0]    in_right_den,
  input logic             in_typing_complete,
  input logic             in_typing_match,
  input logic             out_valid,
  input logic [1:0]       out_status,
  input logic [DW-1:0]    out_product_num,
  input logic [DW-1:0]    out_product_den,
  input logic [LEN_W-1:0] out_need_num_bits,
  input logic [LEN_W-1:0] out_need_den_bits
);

  // an accepted item keeps the block busy
  `RGM_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  // a result ends the item and frees the input side
  `RGM_ASSERT_NEXT(a_done_idle, clk, rst_n, out_valid, !busy && !out_valid)
  // products only on a good result, and reduced below one
  `RGM_ASSERT_NOW(a_ok_fields, clk, rst_n, out_valid,
    (out_status == ST_OK) ?
      (out_product_num != '0 && out_product_num < out_product_den) :
      (out_product_num == '0 && out_product_den == '0))
  // bit lengths only on a capacity result
  `RGM_ASSERT_NOW(a_cap_fields, clk, rst_n, out_valid && out_status != ST_CAPACITY,
    out_need_num_bits == '0 && out_need_den_bits == '0)

endmodule

bind rational_gain_multiply rgm_checker u_rgm_checker (.*);
